[hdl/assert_macros.svh]
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle property failed");

`endif

[hdl/mh3_pkg.sv]
// Shared types, constants and helper functions of the MurmurHash3 bucket block.
package mh3_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned CNT_W = 3;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned DIV_CNT_W = 5;

	localparam logic [WORD_W-1:0] MIX_C1 = 32'hcc9e2d51;
	localparam logic [WORD_W-1:0] MIX_C2 = 32'h1b873593;
	localparam logic [WORD_W-1:0] UPD_ADD = 32'he6546b64;
	localparam logic [WORD_W-1:0] FIN_M1 = 32'h85ebca6b;
	localparam logic [WORD_W-1:0] FIN_M2 = 32'hc2b2ae35;

	localparam logic [CNT_W-1:0] FULL_BYTES = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SEED = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BUCKET = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MIX,
		ST_UPD,
		ST_FIN0,
		ST_FIN1,
		ST_FIN2,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic mix;
		logic update;
		logic fin0;
		logic fin1;
		logic fin2;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic nb_zero;
		logic key_end;
		logic div_last;
	} status_t;

	function automatic logic [WORD_W-1:0] rotl15(input logic [WORD_W-1:0] v);
		rotl15 = {v[WORD_W-16:0], v[WORD_W-1:WORD_W-15]};
	endfunction

	function automatic logic [WORD_W-1:0] rotl13(input logic [WORD_W-1:0] v);
		rotl13 = {v[WORD_W-14:0], v[WORD_W-1:WORD_W-13]};
	endfunction

endpackage

[hdl/mh3_datapath.sv]
// Datapath of the MurmurHash3 bucket block: config registers, mixer, finalizer, divider.
module mh3_datapath
	import mh3_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	input  logic [WORD_W-1:0]    data_word,
	input  logic [CNT_W-1:0]     valid_bytes,
	input  logic                 last_word,
	input  cmd_t                 cmd,
	output status_t              status,
	output logic [WORD_W-1:0]    hash_value,
	output logic [WORD_W-1:0]    bucket_index
);

	logic [WORD_W-1:0]    seed_q;
	logic [WORD_W-1:0]    bucket_q;
	logic                 in_key_q;
	logic [WORD_W-1:0]    hash_q;
	logic [WORD_W-1:0]    total_q;
	logic [WORD_W-1:0]    k_q;
	logic                 full_q;
	logic                 zero_q;
	logic                 end_q;
	logic [WORD_W-1:0]    f_q;
	logic [WORD_W-1:0]    h_q;
	logic [WORD_W-1:0]    rem_q;
	logic [WORD_W-1:0]    sh_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [WORD_W-1:0]    out_hash_q;
	logic [WORD_W-1:0]    out_bucket_q;

	logic [CNT_W-1:0]  nb;
	logic [WORD_W-1:0] masked;
	logic [WORD_W-1:0] x_upd;
	logic [WORD_W-1:0] r_upd;
	logic [WORD_W-1:0] f0;
	logic [WORD_W-1:0] f1;
	logic [WORD_W:0]   trial;
	logic [WORD_W:0]   diff;

	always_comb begin
		nb = (valid_bytes > FULL_BYTES) ? FULL_BYTES : valid_bytes;
		case (nb)
			3'd0: masked = '0;
			3'd1: masked = {24'd0, data_word[7:0]};
			3'd2: masked = {16'd0, data_word[15:0]};
			3'd3: masked = {8'd0, data_word[23:0]};
			default: masked = data_word;
		endcase
		x_upd = hash_q ^ k_q;
		r_upd = rotl13(x_upd);
		f0 = (hash_q ^ total_q) ^ ((hash_q ^ total_q) >> 16);
		f1 = f_q ^ (f_q >> 13);
		// With a bucket count of zero nothing is ever subtracted, so the
		// remainder ends up equal to the hash, as for a count of 2^32.
		trial = {rem_q, sh_q[WORD_W-1]};
		diff = trial - {1'b0, bucket_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			bucket_q <= {{(WORD_W-1){1'b0}}, 1'b1};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SEED: seed_q <= cfg_data;
				REG_BUCKET: bucket_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_key_q <= 1'b0;
		end else if (cmd.accept) begin
			in_key_q <= 1'b1;
		end else if (cmd.fin0) begin
			in_key_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			if (!in_key_q) begin
				hash_q <= seed_q;
				total_q <= {{(WORD_W-CNT_W){1'b0}}, nb};
			end else begin
				total_q <= total_q + {{(WORD_W-CNT_W){1'b0}}, nb};
			end
			k_q <= masked * MIX_C1;
			full_q <= (nb == FULL_BYTES);
			zero_q <= (nb == '0);
			end_q <= last_word || (nb != FULL_BYTES);
		end
		if (cmd.mix) begin
			k_q <= rotl15(k_q) * MIX_C2;
		end
		if (cmd.update) begin
			if (full_q) begin
				hash_q <= (r_upd << 2) + r_upd + UPD_ADD;
			end else begin
				hash_q <= x_upd;
			end
		end
		if (cmd.fin0) begin
			f_q <= f0 * FIN_M1;
		end
		if (cmd.fin1) begin
			f_q <= f1 * FIN_M2;
		end
		if (cmd.fin2) begin
			h_q <= f_q ^ (f_q >> 16);
			sh_q <= f_q ^ (f_q >> 16);
			rem_q <= '0;
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
			sh_q <= {sh_q[WORD_W-2:0], 1'b0};
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.out_load) begin
			out_hash_q <= h_q;
			out_bucket_q <= rem_q;
		end
	end

	assign status.nb_zero = zero_q;
	assign status.key_end = end_q;
	assign status.div_last = &cnt_q;
	assign hash_value = out_hash_q;
	assign bucket_index = out_bucket_q;

endmodule

[hdl/mh3_ctrl.sv]
// Controller state machine of the MurmurHash3 bucket block.
module mh3_ctrl
	import mh3_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = ST_MIX;
				end
			end
			ST_MIX: begin
				if (status.nb_zero) begin
					state_d = ST_FIN0;
				end else begin
					cmd.mix = 1'b1;
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_d = status.key_end ? ST_FIN0 : ST_IDLE;
			end
			ST_FIN0: begin
				cmd.fin0 = 1'b1;
				state_d = ST_FIN1;
			end
			ST_FIN1: begin
				cmd.fin1 = 1'b1;
				state_d = ST_FIN2;
			end
			ST_FIN2: begin
				cmd.fin2 = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

[hdl/murmur3_32_hash_bucket.sv]
// Top level of the streaming MurmurHash3 (x86_32) hash and bucket select block.
//
// The block hashes a key that arrives as little-endian 32-bit words on the
// slave stream and returns one transaction per key on the master stream: the
// finalized MurmurHash3 of the key and that hash modulo the bucket count.
// Each input transaction carries a word and a count of valid low-order bytes
// (0 to 4, larger counts act as 4); tlast marks the final word, and a word
// with fewer than four bytes also ends the key. The seed is sampled when the
// first word of a key is taken, so writing the seed register mid-key takes
// effect from the next key. A bucket count of zero acts as 2^32, so the
// bucket index then equals the hash. A full word that does not end the
// key passes through accept, second mix multiply and hash update, and the
// block takes no new word until that update is done. A key's final word
// goes through mixing, the finalizer's multiply and xor-shift steps,
// bit-serial restoring division for the bucket index and the load of the
// output register; an empty final word skips the second mix multiply and
// the hash update. The result waits in an output register, and the next
// key's first word is accepted while it waits; a second result waits for
// the first to be taken.
module murmur3_32_hash_bucket
	import mh3_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration write port: index 0 is the seed, index 1 the bucket count.
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	// Slave stream.
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [39:0]          s_axis_tdata,  // [31:0] data_word, [34:32] valid_bytes
	input  logic                 s_axis_tlast,  // last_word
	// Master stream.
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [63:0]          m_axis_tdata   // [31:0] hash_value, [63:32] bucket_index
);

	cmd_t              cmd;
	status_t           status;
	logic [WORD_W-1:0] hash_value;
	logic [WORD_W-1:0] bucket_index;

	// The controller sequences the mix, finalizer and division steps and owns
	// the handshakes; the datapath holds every payload register.
	mh3_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	// Bits 39:35 of the input data are padding and are ignored.
	mh3_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.data_word    (s_axis_tdata[31:0]),
		.valid_bytes  (s_axis_tdata[34:32]),
		.last_word    (s_axis_tlast),
		.cmd          (cmd),
		.status       (status),
		.hash_value   (hash_value),
		.bucket_index (bucket_index)
	);

	assign m_axis_tdata = {bucket_index, hash_value};

endmodule

[hdl/mh3_checker.sv]
// Port-level checker for the MurmurHash3 bucket block, bound to the top level.
`include "assert_macros.svh"

module mh3_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata
);

	// A stalled result transaction stays valid and unchanged.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))

	// The block works on one word at a time: after a transaction it is busy.
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_axis_tvalid && s_axis_tready,
		!s_axis_tready)

	// A result only appears after the block has been busy finishing a key.
	`ASSERT_IMPL(a_result_after_busy, clk, arst_n, $rose(m_axis_tvalid),
		!$past(s_axis_tready))

endmodule

bind murmur3_32_hash_bucket mh3_checker u_mh3_checker (.*);
